[design/ctr_pkg.sv]
// Shared types and constants for the CAN transport-protocol reassembler.
package ctr_pkg;

    // Frame classes decided by the front end from the type nibble.
    typedef enum logic [1:0] {
        KIND_SINGLE      = 2'd0,
        KIND_FIRST       = 2'd1,
        KIND_CONSECUTIVE = 2'd2,
        KIND_OTHER       = 2'd3
    } kind_t;

    // Result status codes.
    localparam logic [2:0] STATUS_IN_PROGRESS = 3'd0;
    localparam logic [2:0] STATUS_COMPLETE    = 3'd1;
    localparam logic [2:0] STATUS_BAD_TYPE    = 3'd2;
    localparam logic [2:0] STATUS_SEQ_ERROR   = 3'd3;
    localparam logic [2:0] STATUS_BAD_SINGLE  = 3'd4;

    // Type nibbles of the frame header byte.
    localparam logic [3:0] TYPE_SINGLE      = 4'h0;
    localparam logic [3:0] TYPE_FIRST       = 4'h1;
    localparam logic [3:0] TYPE_CONSECUTIVE = 4'h2;

    // Flow control frame constants.
    localparam logic [3:0]  FC_TYPE_NIBBLE = 4'h3;
    localparam logic [39:0] FC_PADDING     = 40'h55_5555_5555;

    // Frame and payload geometry.
    localparam int FRAME_BYTES   = 8;
    localparam int PAYLOAD_BYTES = 7;
    localparam logic [2:0] FF_PAYLOAD_MAX = 3'd6;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_FLOW_STATUS     = 2'd0;
    localparam logic [1:0] REG_BLOCK_SIZE      = 2'd1;
    localparam logic [1:0] REG_SEPARATION_TIME = 2'd2;

    // Register reset values.
    localparam logic [3:0] FLOW_STATUS_RESET     = 4'd0;
    localparam logic [7:0] BLOCK_SIZE_RESET      = 8'd8;
    localparam logic [7:0] SEPARATION_TIME_RESET = 8'd25;

    // One classified frame waiting between front and back.
    typedef struct packed {
        kind_t       kind;
        logic [63:0] frame;     // bytes beyond the frame length are zero
        logic [2:0]  data_len;  // frame length minus the header byte
    } entry_t;

    // Configuration seen by the back end.
    typedef struct packed {
        logic [3:0] flow_status;
        logic [7:0] block_size;
        logic [7:0] separation_time;
    } cfg_t;

    // One result beat.
    typedef struct packed {
        logic [2:0]  status;
        logic [55:0] payload;
        logic [2:0]  payload_count;
        logic [11:0] payload_offset;
        logic [11:0] message_length;
        logic        send_flow_control;
        logic [63:0] flow_frame;
    } result_t;

endpackage

[design/ctr_front.sv]
// Front end: clamps the frame length, zeroes unused bytes and classifies the frame.
module ctr_front (
    input  logic [3:0]     frame_len,
    input  logic [63:0]    frame_bytes,
    output ctr_pkg::entry_t entry
);

    logic [3:0]  len_clamped;
    logic [63:0] masked;
    logic [3:0]  type_nibble;

    // Lengths above eight count as eight.
    assign len_clamped = (frame_len > 4'd8) ? 4'd8 : frame_len;

    // Bytes past the frame length read as zero.
    always_comb begin
        masked = '0;
        for (int i = 0; i < ctr_pkg::FRAME_BYTES; i++) begin
            if (4'(i) < len_clamped) begin
                masked[63 - 8*i -: 8] = frame_bytes[63 - 8*i -: 8];
            end
        end
    end

    assign type_nibble = masked[63:60];

    // Classify by the type nibble of the header byte.
    always_comb begin
        entry.frame = masked;
        entry.data_len = (len_clamped == 4'd0) ? 3'd0 : 3'(len_clamped - 4'd1);
        unique case (type_nibble)
            ctr_pkg::TYPE_SINGLE:      entry.kind = ctr_pkg::KIND_SINGLE;
            ctr_pkg::TYPE_FIRST:       entry.kind = ctr_pkg::KIND_FIRST;
            ctr_pkg::TYPE_CONSECUTIVE: entry.kind = ctr_pkg::KIND_CONSECUTIVE;
            default:                   entry.kind = ctr_pkg::KIND_OTHER;
        endcase
    end

endmodule

[design/ctr_queue.sv]
// Two-entry queue that decouples the front end from the back end.
module ctr_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  ctr_pkg::entry_t wr_entry,
    output logic            rd_valid,
    input  logic            rd_ready,
    output ctr_pkg::entry_t rd_entry
);

    ctr_pkg::entry_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_entry = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

[design/ctr_back.sv]
// Back end: reassembly state, result formation and the output register.
module ctr_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  ctr_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  ctr_pkg::entry_t  in_entry,
    output logic             out_valid,
    input  logic             out_ready,
    output ctr_pkg::result_t out_result
);

    logic             receiving_reg, receiving_next;
    logic [3:0]       exp_seq_reg, exp_seq_next;
    logic [11:0]      received_reg, received_next;
    logic [11:0]      total_reg, total_next;
    logic             out_valid_reg;
    ctr_pkg::result_t out_reg, out_next;
    logic             take;

    logic [7:0]  b0;
    logic [3:0]  lo;
    logic [11:0] tl;
    logic [2:0]  ff_count;
    logic [11:0] remaining;
    logic [2:0]  cf_count;
    logic [11:0] received_sum;
    logic [63:0] flow_word;

    // Keep the first count bytes of a 56-bit payload, zero the rest.
    function automatic logic [55:0] keep_bytes(input logic [55:0] p, input logic [2:0] count);
        logic [55:0] r;
        r = '0;
        for (int i = 0; i < ctr_pkg::PAYLOAD_BYTES; i++) begin
            if (3'(i) < count) begin
                r[55 - 8*i -: 8] = p[55 - 8*i -: 8];
            end
        end
        return r;
    endfunction

    // The output register can take a new result when empty or being drained.
    assign take      = in_valid && (!out_valid_reg || out_ready);
    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_result = out_reg;

    // Header fields and length arithmetic.
    assign b0           = in_entry.frame[63:56];
    assign lo           = b0[3:0];
    assign tl           = {lo, in_entry.frame[55:48]};
    assign ff_count     = (tl < 12'd6) ? tl[2:0] : ctr_pkg::FF_PAYLOAD_MAX;
    assign remaining    = total_reg - received_reg;
    assign cf_count     = ({9'd0, in_entry.data_len} < remaining) ? in_entry.data_len
                                                                  : remaining[2:0];
    assign received_sum = received_reg + {9'd0, cf_count};
    assign flow_word    = {ctr_pkg::FC_TYPE_NIBBLE, cfg.flow_status, cfg.block_size,
                           cfg.separation_time, ctr_pkg::FC_PADDING};

    // Result and next state for the frame at the head of the queue.
    always_comb begin
        out_next       = '0;
        receiving_next = receiving_reg;
        exp_seq_next   = exp_seq_reg;
        received_next  = received_reg;
        total_next     = total_reg;
        if (!receiving_reg) begin
            case (in_entry.kind)
                ctr_pkg::KIND_SINGLE: begin
                    if (lo[3]) begin
                        out_next.status = ctr_pkg::STATUS_BAD_SINGLE;
                    end else begin
                        out_next.status         = ctr_pkg::STATUS_COMPLETE;
                        out_next.payload        = keep_bytes(in_entry.frame[55:0], lo[2:0]);
                        out_next.payload_count  = lo[2:0];
                        out_next.message_length = {9'd0, lo[2:0]};
                    end
                end
                ctr_pkg::KIND_FIRST: begin
                    out_next.payload           = keep_bytes({in_entry.frame[47:0], 8'h00},
                                                            ff_count);
                    out_next.payload_count     = ff_count;
                    out_next.message_length    = tl;
                    out_next.send_flow_control = 1'b1;
                    out_next.flow_frame        = flow_word;
                    if (tl <= 12'd6) begin
                        out_next.status = ctr_pkg::STATUS_COMPLETE;
                    end else begin
                        out_next.status = ctr_pkg::STATUS_IN_PROGRESS;
                        receiving_next  = 1'b1;
                        exp_seq_next    = 4'd1;
                        received_next   = 12'd6;
                        total_next      = tl;
                    end
                end
                default: begin
                    out_next.status = ctr_pkg::STATUS_BAD_TYPE;
                end
            endcase
        end else begin
            if (in_entry.kind != ctr_pkg::KIND_CONSECUTIVE) begin
                out_next.status = ctr_pkg::STATUS_BAD_TYPE;
                receiving_next  = 1'b0;
            end else if (lo != exp_seq_reg) begin
                out_next.status = ctr_pkg::STATUS_SEQ_ERROR;
                receiving_next  = 1'b0;
            end else begin
                out_next.payload        = keep_bytes(in_entry.frame[55:0], cf_count);
                out_next.payload_count  = cf_count;
                out_next.payload_offset = received_reg;
                out_next.message_length = total_reg;
                received_next           = received_sum;
                exp_seq_next            = exp_seq_reg + 4'd1;
                if (received_sum >= total_reg) begin
                    out_next.status = ctr_pkg::STATUS_COMPLETE;
                    receiving_next  = 1'b0;
                end else begin
                    out_next.status = ctr_pkg::STATUS_IN_PROGRESS;
                end
            end
            // Leaving the receive state restores the idle values.
            if (!receiving_next) begin
                exp_seq_next  = 4'd1;
                received_next = 12'd0;
                total_next    = 12'd0;
            end
        end
    end

    // Reassembly state and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            receiving_reg <= 1'b0;
            exp_seq_reg   <= 4'd1;
            received_reg  <= 12'd0;
            total_reg     <= 12'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                receiving_reg <= receiving_next;
                exp_seq_reg   <= exp_seq_next;
                received_reg  <= received_next;
                total_reg     <= total_next;
            end
            if (take) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    // While idle the counters sit at their idle values.
    a_idle_values: assert property (@(posedge aclk) disable iff (!aresetn)
        !receiving_reg |-> (exp_seq_reg == 4'd1) && (received_reg == 12'd0)
                           && (total_reg == 12'd0))
        else $error("idle state counters not cleared");

    // While receiving, fewer bytes have arrived than the message holds.
    a_recv_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        receiving_reg |-> (received_reg < total_reg))
        else $error("receive count reached message length while receiving");

    // Any result other than in progress leaves the block idle.
    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && (out_next.status != ctr_pkg::STATUS_IN_PROGRESS)) |=> !receiving_reg)
        else $error("still receiving after a final result");
`endif

endmodule

[design/can_tp_reassembler.sv]
// Top level: stream ports, configuration registers, front end, queue and back end.
// A frame accepted on the input is written into the queue, and its result beat is
// registered in the back end's output register when the queue entry is taken.
// Throughput: one frame per cycle while m_tready is high; the two-entry queue and the
// output register let the input take two more frames while one result waits on m_tready.
// Reset: synchronous active-low aresetn empties the queue, clears the output valid
// and the reassembly state, and restores the register defaults.
module can_tp_reassembler (
    input  logic         aclk,
    input  logic         aresetn,
    // Input beat.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,  // frame_len[3:0], frame_bytes[67:4], zero fill
    // Result beat.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,  // payload[55:0], payload_count[58:56],
                                   // payload_offset[70:59], message_length[82:71],
                                   // send_flow_control[83], flow_frame[147:84], zero fill
    output logic [2:0]   m_tuser,  // status[2:0]
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [3:0] flow_status_reg;
    logic [7:0] block_size_reg;
    logic [7:0] separation_time_reg;
    logic       cfg_write;

    ctr_pkg::cfg_t    cfg;
    ctr_pkg::entry_t  front_entry;
    ctr_pkg::entry_t  q_entry;
    logic             q_valid;
    logic             q_ready;
    ctr_pkg::result_t result;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flow_status_reg     <= ctr_pkg::FLOW_STATUS_RESET;
            block_size_reg      <= ctr_pkg::BLOCK_SIZE_RESET;
            separation_time_reg <= ctr_pkg::SEPARATION_TIME_RESET;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                ctr_pkg::REG_FLOW_STATUS:     flow_status_reg     <= pwdata[3:0];
                ctr_pkg::REG_BLOCK_SIZE:      block_size_reg      <= pwdata[7:0];
                ctr_pkg::REG_SEPARATION_TIME: separation_time_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (paddr[3:2])
            ctr_pkg::REG_FLOW_STATUS:     prdata = {28'd0, flow_status_reg};
            ctr_pkg::REG_BLOCK_SIZE:      prdata = {24'd0, block_size_reg};
            ctr_pkg::REG_SEPARATION_TIME: prdata = {24'd0, separation_time_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    assign cfg.flow_status     = flow_status_reg;
    assign cfg.block_size      = block_size_reg;
    assign cfg.separation_time = separation_time_reg;

    // Front end classification.
    ctr_front u_front (
        .frame_len   (s_tdata[3:0]),
        .frame_bytes (s_tdata[67:4]),
        .entry       (front_entry)
    );

    // Queue between front and back.
    ctr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_entry (front_entry),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_entry (q_entry)
    );

    // Back end reassembly.
    ctr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_entry   (q_entry),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Result packing.
    assign m_tuser = result.status;
    assign m_tdata = {4'd0, result.flow_frame, result.send_flow_control,
                      result.message_length, result.payload_offset,
                      result.payload_count, result.payload};

endmodule
